// ===== rtl/fan_gear_threshold_controller_defines.svh =====
// assertion macros for the fan gear threshold controller
// self-contained, included by the top level only
`ifndef FAN_GEAR_THRESHOLD_CONTROLLER_DEFINES_SVH
`define FAN_GEAR_THRESHOLD_CONTROLLER_DEFINES_SVH

// same-cycle implication, checked at every rising edge out of reset
`define FGTC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fgtc check failed");

// next-cycle implication
`define FGTC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fgtc check failed");

`endif

// ===== rtl/fgtc_pkg.sv =====
// shared types, codes and helpers of the fan gear threshold controller
// no dependencies
package fgtc_pkg;

   localparam int DEGREE_W   = 12;
   localparam int LIMIT_W    = 7;
   localparam int STEP_W     = 5;
   localparam int SLOT_W     = 4;
   localparam int RAW_W      = 16;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_IDX_W  = 3;
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   // request codes
   localparam logic [1:0] REQ_SAMPLE = 2'd0;
   localparam logic [1:0] REQ_MODE   = 2'd1;
   localparam logic [1:0] REQ_UP     = 2'd2;
   localparam logic [1:0] REQ_DOWN   = 2'd3;

   // menu codes
   localparam logic [1:0] MENU_NORMAL     = 2'd0;
   localparam logic [1:0] MENU_EDIT_UPPER = 2'd1;
   localparam logic [1:0] MENU_EDIT_LOWER = 2'd2;

   // gear codes
   localparam logic [1:0] GEAR_OFF  = 2'd0;
   localparam logic [1:0] GEAR_MID  = 2'd1;
   localparam logic [1:0] GEAR_FULL = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_ALARM_LIMIT   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ADJUST_STEP   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_PWM_OFF_SLOTS = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_PWM_ON_SLOTS  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_UPPER_FLOOR   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_UPPER_CEILING = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_LOWER_CEILING = 3'd6;

   // register reset values
   localparam logic [DEGREE_W-1:0] ALARM_LIMIT_RST   = 12'd45;
   localparam logic [STEP_W-1:0]   ADJUST_STEP_RST   = 5'd5;
   localparam logic [SLOT_W-1:0]   PWM_OFF_SLOTS_RST = 4'd3;
   localparam logic [SLOT_W-1:0]   PWM_ON_SLOTS_RST  = 4'd6;
   localparam logic [LIMIT_W-1:0]  UPPER_FLOOR_RST   = 7'd10;
   localparam logic [LIMIT_W-1:0]  UPPER_CEILING_RST = 7'd100;
   localparam logic [LIMIT_W-1:0]  LOWER_CEILING_RST = 7'd95;

   // state reset values
   localparam logic [LIMIT_W-1:0] UPPER_LIMIT_RST = 7'd30;
   localparam logic [LIMIT_W-1:0] LOWER_LIMIT_RST = 7'd20;

   localparam logic [SLOT_W-1:0] SLOTS_MIN = 4'd1;
   localparam logic [SLOT_W-1:0] SLOTS_MAX = 4'd8;

   typedef struct packed {
      logic [DEGREE_W-1:0] alarm_limit;
      logic [STEP_W-1:0]   adjust_step;
      logic [SLOT_W-1:0]   pwm_off_slots;
      logic [SLOT_W-1:0]   pwm_on_slots;
      logic [LIMIT_W-1:0]  upper_floor;
      logic [LIMIT_W-1:0]  upper_ceiling;
      logic [LIMIT_W-1:0]  lower_ceiling;
   } cfg_type;

   // one classified item: a snapshot of the outputs plus the slot plan
   typedef struct packed {
      logic [1:0]          menu_state;
      logic [DEGREE_W-1:0] shown_value;
      logic [1:0]          gear_level;
      logic                fan_drive;
      logic                alarm_out;
      logic [LIMIT_W-1:0]  upper_now;
      logic [LIMIT_W-1:0]  lower_now;
      logic                pulsed;
      logic [SLOT_W-1:0]   off_slots;
      logic [SLOT_W-1:0]   on_slots;
   } job_type;

   function automatic logic [SLOT_W-1:0] clamp_slots(input logic [SLOT_W-1:0] n);
      logic [SLOT_W-1:0] r;
      if (n < SLOTS_MIN) r = SLOTS_MIN;
      else if (n > SLOTS_MAX) r = SLOTS_MAX;
      else r = n;
      return r;
   endfunction

endpackage

// ===== rtl/fgtc_front.sv =====
// front part: owns menu, limits and fan state, classifies each word into a job
// depends on fgtc_pkg
module fgtc_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic [1:0]                    req_type,
   input  logic [fgtc_pkg::RAW_W-1:0]    req_temp_raw,
   input  fgtc_pkg::cfg_type             cfg,
   output fgtc_pkg::job_type             job
);
   import fgtc_pkg::*;

   logic [1:0]          menu_ff, menu_in;
   logic [LIMIT_W-1:0]  upper_ff, upper_in;
   logic [LIMIT_W-1:0]  lower_ff, lower_in;
   logic [DEGREE_W-1:0] degrees_ff, degrees_in;
   logic [1:0]          gear_ff, gear_in;
   logic                fan_ff, fan_in;
   logic                alarm_ff, alarm_in;
   logic [DEGREE_W-1:0] sample_deg;
   logic [LIMIT_W:0]    up_sum_upper, up_sum_lower;
   logic [LIMIT_W:0]    down_edge;
   logic                pulsed;

   assign sample_deg   = req_temp_raw[RAW_W-1:RAW_W-DEGREE_W];
   assign up_sum_upper = {1'b0, upper_ff} + {{(LIMIT_W+1-STEP_W){1'b0}}, cfg.adjust_step};
   assign up_sum_lower = {1'b0, lower_ff} + {{(LIMIT_W+1-STEP_W){1'b0}}, cfg.adjust_step};
   assign down_edge    = {1'b0, cfg.upper_floor}
                       + {{(LIMIT_W+1-STEP_W){1'b0}}, cfg.adjust_step};

   always_comb begin
      menu_in    = menu_ff;
      upper_in   = upper_ff;
      lower_in   = lower_ff;
      degrees_in = degrees_ff;
      gear_in    = gear_ff;
      fan_in     = fan_ff;
      alarm_in   = alarm_ff;
      pulsed     = 1'b0;
      unique case (req_type)
         REQ_MODE: begin
            unique case (menu_ff)
               MENU_NORMAL:     menu_in = MENU_EDIT_UPPER;
               MENU_EDIT_UPPER: menu_in = MENU_EDIT_LOWER;
               default:         menu_in = MENU_NORMAL;
            endcase
         end
         REQ_UP: begin
            if (menu_ff == MENU_EDIT_UPPER) begin
               upper_in = (up_sum_upper >= {1'b0, cfg.upper_ceiling}) ?
                          cfg.upper_ceiling : up_sum_upper[LIMIT_W-1:0];
            end else if (menu_ff == MENU_EDIT_LOWER) begin
               lower_in = (up_sum_lower >= {1'b0, cfg.lower_ceiling}) ?
                          cfg.lower_ceiling : up_sum_lower[LIMIT_W-1:0];
            end
         end
         REQ_DOWN: begin
            if (menu_ff == MENU_EDIT_UPPER) begin
               upper_in = ({1'b0, upper_ff} <= down_edge) ? cfg.upper_floor :
                          upper_ff - {{(LIMIT_W-STEP_W){1'b0}}, cfg.adjust_step};
            end else if (menu_ff == MENU_EDIT_LOWER) begin
               // floor at zero
               lower_in = (lower_ff <= {{(LIMIT_W-STEP_W){1'b0}}, cfg.adjust_step}) ?
                          '0 : lower_ff - {{(LIMIT_W-STEP_W){1'b0}}, cfg.adjust_step};
            end
         end
         default: begin
            if (menu_ff == MENU_NORMAL) begin
               degrees_in = sample_deg;
               alarm_in   = (sample_deg >= cfg.alarm_limit) ? ~alarm_ff : 1'b0;
               if (sample_deg > {{(DEGREE_W-LIMIT_W){1'b0}}, upper_ff}) begin
                  gear_in = GEAR_FULL;
                  fan_in  = 1'b1;
               end else if (sample_deg < {{(DEGREE_W-LIMIT_W){1'b0}}, lower_ff}) begin
                  gear_in = GEAR_OFF;
                  fan_in  = 1'b0;
               end else begin
                  gear_in = GEAR_MID;
                  fan_in  = 1'b1;
                  pulsed  = 1'b1;
               end
            end
         end
      endcase
   end

   always_comb begin
      job.menu_state = menu_in;
      unique case (menu_in)
         MENU_EDIT_UPPER: job.shown_value = {{(DEGREE_W-LIMIT_W){1'b0}}, upper_in};
         MENU_EDIT_LOWER: job.shown_value = {{(DEGREE_W-LIMIT_W){1'b0}}, lower_in};
         default:         job.shown_value = degrees_in;
      endcase
      job.gear_level = gear_in;
      job.fan_drive  = fan_in;
      job.alarm_out  = alarm_in;
      job.upper_now  = upper_in;
      job.lower_now  = lower_in;
      job.pulsed     = pulsed;
      job.off_slots  = clamp_slots(cfg.pwm_off_slots);
      job.on_slots   = clamp_slots(cfg.pwm_on_slots);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         menu_ff    <= MENU_NORMAL;
         upper_ff   <= UPPER_LIMIT_RST;
         lower_ff   <= LOWER_LIMIT_RST;
         degrees_ff <= '0;
         gear_ff    <= GEAR_OFF;
         fan_ff     <= 1'b0;
         alarm_ff   <= 1'b0;
      end else if (accept) begin
         menu_ff    <= menu_in;
         upper_ff   <= upper_in;
         lower_ff   <= lower_in;
         degrees_ff <= degrees_in;
         gear_ff    <= gear_in;
         fan_ff     <= fan_in;
         alarm_ff   <= alarm_in;
      end
   end

endmodule

// ===== rtl/fgtc_queue.sv =====
// short job queue between front and back, show-ahead read
// depends on fgtc_pkg
module fgtc_queue #(
   parameter int DEPTH = fgtc_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               wr_en,
   input  fgtc_pkg::job_type  wr_job,
   output logic               full,
   input  logic               rd_en,
   output fgtc_pkg::job_type  rd_job,
   output logic               not_empty
);
   import fgtc_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type            store_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign rd_job    = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (rd_en) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (wr_en && !rd_en) count_in = count_ff + 1'b1;
      else if (rd_en && !wr_en) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_ptr_ff] <= wr_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== rtl/fgtc_back.sv =====
// back part: expands each job into its result words, one word per cycle while pop is high
// depends on fgtc_pkg
module fgtc_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               job_avail,
   input  fgtc_pkg::job_type  job,
   output logic               job_take,
   output logic               empty,
   input  logic               pop,
   output fgtc_pkg::job_type  cur,
   output logic               cur_fan,
   output logic               cur_last
);
   import fgtc_pkg::*;

   logic              valid_ff;
   job_type           job_ff;
   logic [SLOT_W-1:0] off_left_ff, off_left_in;
   logic [SLOT_W-1:0] on_left_ff, on_left_in;
   logic              advance;

   assign empty    = !valid_ff;
   assign cur      = job_ff;
   // pulsed jobs: off slots first, then on slots
   assign cur_fan  = job_ff.pulsed ? (off_left_ff == '0) : job_ff.fan_drive;
   assign cur_last = job_ff.pulsed ?
                     ((off_left_ff == '0) && (on_left_ff == SLOT_W'(1))) : 1'b1;
   assign advance  = valid_ff && pop;
   assign job_take = job_avail && (!valid_ff || (advance && cur_last));

   always_comb begin
      off_left_in = off_left_ff;
      on_left_in  = on_left_ff;
      if (job_take) begin
         off_left_in = job.off_slots;
         on_left_in  = job.on_slots;
      end else if (advance) begin
         if (off_left_ff != '0) off_left_in = off_left_ff - 1'b1;
         else if (on_left_ff != '0) on_left_in = on_left_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (job_take) begin
         valid_ff <= 1'b1;
      end else if (advance && cur_last) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (job_take) begin
         job_ff <= job;
      end
      off_left_ff <= off_left_in;
      on_left_ff  <= on_left_in;
   end

endmodule

// ===== rtl/fan_gear_threshold_controller.sv =====
// fan gear threshold controller, top level with register block and checks
// depends on fgtc_pkg, fgtc_front, fgtc_queue, fgtc_back and the defines header
//
// usage
//   request side works like a queue: drive req_type and req_temp_raw, raise push;
//   the word is taken at a rising edge with push high and full low
//   result side works like a queue too: while empty is low the oldest result
//   word sits on the rsp_ ports, it is taken at a rising edge with pop high
//   a taken request is stored in the job queue, then loaded into the back part
//   throughput: a request is taken every cycle while the job queue has room;
//   keys, ignored samples and off or full gear samples give one result word,
//   middle gear samples give 2 to 16 words, one per cycle while pop is high,
//   set by the slot expander in the back part
//   when pop stays low the back part holds its word, the job queue fills and
//   full rises; nothing is dropped
//   reset (synchronous) empties the queue, puts the menu in normal mode,
//   limits at 30 and 20 and loads the register reset values
//   registers must be written over the apb-style port only while idle, which the
//   block does not enforce; reads return the stored values, pready is tied high
module fan_gear_threshold_controller #(
   parameter int QUEUE_DEPTH = fgtc_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                push,
   output logic                                full,
   input  logic [1:0]                          req_type,
   input  logic [fgtc_pkg::RAW_W-1:0]          req_temp_raw,
   // result channel
   output logic                                empty,
   input  logic                                pop,
   output logic [1:0]                          rsp_menu_state,
   output logic [fgtc_pkg::DEGREE_W-1:0]       rsp_shown_value,
   output logic [1:0]                          rsp_gear_level,
   output logic                                rsp_fan_drive,
   output logic                                rsp_alarm_out,
   output logic [fgtc_pkg::LIMIT_W-1:0]        rsp_upper_now,
   output logic [fgtc_pkg::LIMIT_W-1:0]        rsp_lower_now,
   output logic                                rsp_last_slot,
   // register port
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [fgtc_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [fgtc_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [fgtc_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready
);
   import fgtc_pkg::*;

   `include "fan_gear_threshold_controller_defines.svh"

   cfg_type                cfg_ff;
   logic                   csr_wr;
   logic [CSR_IDX_W-1:0]   csr_idx;
   logic                   accept;
   job_type                front_job;
   job_type                queue_job;
   logic                   queue_not_empty;
   logic                   job_take;
   job_type                cur_job;
   logic                   cur_fan;
   logic                   cur_last;

   // register block
   assign pready  = 1'b1;
   assign csr_idx = paddr[CSR_ADDR_W-1:2];
   assign csr_wr  = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.alarm_limit   <= ALARM_LIMIT_RST;
         cfg_ff.adjust_step   <= ADJUST_STEP_RST;
         cfg_ff.pwm_off_slots <= PWM_OFF_SLOTS_RST;
         cfg_ff.pwm_on_slots  <= PWM_ON_SLOTS_RST;
         cfg_ff.upper_floor   <= UPPER_FLOOR_RST;
         cfg_ff.upper_ceiling <= UPPER_CEILING_RST;
         cfg_ff.lower_ceiling <= LOWER_CEILING_RST;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_ALARM_LIMIT:   cfg_ff.alarm_limit   <= pwdata[DEGREE_W-1:0];
            REG_ADJUST_STEP:   cfg_ff.adjust_step   <= pwdata[STEP_W-1:0];
            REG_PWM_OFF_SLOTS: cfg_ff.pwm_off_slots <= pwdata[SLOT_W-1:0];
            REG_PWM_ON_SLOTS:  cfg_ff.pwm_on_slots  <= pwdata[SLOT_W-1:0];
            REG_UPPER_FLOOR:   cfg_ff.upper_floor   <= pwdata[LIMIT_W-1:0];
            REG_UPPER_CEILING: cfg_ff.upper_ceiling <= pwdata[LIMIT_W-1:0];
            REG_LOWER_CEILING: cfg_ff.lower_ceiling <= pwdata[LIMIT_W-1:0];
            default: ;  // unmapped address, write dropped
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      unique case (csr_idx)
         REG_ALARM_LIMIT:   prdata = CSR_DATA_W'(cfg_ff.alarm_limit);
         REG_ADJUST_STEP:   prdata = CSR_DATA_W'(cfg_ff.adjust_step);
         REG_PWM_OFF_SLOTS: prdata = CSR_DATA_W'(cfg_ff.pwm_off_slots);
         REG_PWM_ON_SLOTS:  prdata = CSR_DATA_W'(cfg_ff.pwm_on_slots);
         REG_UPPER_FLOOR:   prdata = CSR_DATA_W'(cfg_ff.upper_floor);
         REG_UPPER_CEILING: prdata = CSR_DATA_W'(cfg_ff.upper_ceiling);
         REG_LOWER_CEILING: prdata = CSR_DATA_W'(cfg_ff.lower_ceiling);
         default:           prdata = '0;
      endcase
   end

   // front: state update and classification at accept time
   assign accept = push && !full;

   fgtc_front u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .req_type     (req_type),
      .req_temp_raw (req_temp_raw),
      .cfg          (cfg_ff),
      .job          (front_job)
   );

   // job queue decouples the front from result back-pressure
   fgtc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (accept),
      .wr_job    (front_job),
      .full      (full),
      .rd_en     (job_take),
      .rd_job    (queue_job),
      .not_empty (queue_not_empty)
   );

   // back: slot expansion, registered result word
   fgtc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_avail (queue_not_empty),
      .job       (queue_job),
      .job_take  (job_take),
      .empty     (empty),
      .pop       (pop),
      .cur       (cur_job),
      .cur_fan   (cur_fan),
      .cur_last  (cur_last)
   );

   assign rsp_menu_state  = cur_job.menu_state;
   assign rsp_shown_value = cur_job.shown_value;
   assign rsp_gear_level  = cur_job.gear_level;
   assign rsp_fan_drive   = cur_fan;
   assign rsp_alarm_out   = cur_job.alarm_out;
   assign rsp_upper_now   = cur_job.upper_now;
   assign rsp_lower_now   = cur_job.lower_now;
   assign rsp_last_slot   = cur_last;

   // checks
   // a word that is not the last of its item is always followed by another
   `FGTC_ASSERT_NEXT(a_burst_continues, clock, reset,
      !empty && pop && !rsp_last_slot, !empty)
   // only middle gear words come in bursts
   `FGTC_ASSERT_NOW(a_single_word, clock, reset,
      !empty && (rsp_gear_level != GEAR_MID), rsp_last_slot)
   // off gear never drives the fan
   `FGTC_ASSERT_NOW(a_off_gear_fan, clock, reset,
      !empty && (rsp_gear_level == GEAR_OFF), !rsp_fan_drive)
   // a stalled word holds its drive level
   `FGTC_ASSERT_NEXT(a_stall_holds, clock, reset,
      !empty && !pop, $stable(rsp_fan_drive) && $stable(rsp_last_slot))

endmodule
